@@ sv/sorted_array_set_assert.svh @@
// Assertion macros used by the checker of the sorted set block.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef SORTED_ARRAY_SET_ASSERT_SVH
`define SORTED_ARRAY_SET_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define SAS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_array_set: same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define SAS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_array_set: next-cycle check failed");

`endif

@@ sv/sas_pkg.sv @@
// Shared types and constants of the sorted set block.
// No dependencies; used by every module of the block and by its checker.
package sas_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VALUE_W      = 32;
    localparam int OUT_CNT_W    = 7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_CLEAR  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                     kind;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic                 was_present;
        logic                 changed;
        logic [OUT_CNT_W-1:0] entry_count;
        logic                 is_empty;
        logic                 is_full;
    } res_t;

endpackage

@@ sv/sorted_array_set.sv @@
// Sorted set of distinct signed 32-bit values: top level.
// Depends on sas_pkg, sas_ctrl and sas_mem.
//
// cmd channel (cmd_valid / cmd_stall / cmd) carries one operation and a value:
// insert, delete, membership query or clear. res channel (res_valid /
// res_stall / res) returns exactly one result per command: was_present,
// changed, entry_count, is_empty and is_full. A transfer happens at a rising
// edge with valid high and stall low.
// One command at a time; cmd_stall is low only while the sequencer idles.
// A clear goes straight to the result register; a query or delete on an empty
// set passes through the act state first, and an insert into one also through
// the put state. A linear search otherwise reads the entries in order, then an
// insert or delete shifts the later entries at one per cycle through the single
// read and write port pair; the sequencer returns to idle, ready for the next
// command, once the result register loads.
// rst_n clears the count and the sequencer; the element store has no reset
// and is only read below the count, so no clearing pass is needed.
// While res_stall is high the result in the output register is held, and
// the next finished result waits in the sequencer.
module sorted_array_set #(
    parameter int CAPACITY = sas_pkg::CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  sas_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_stall,
    output sas_pkg::res_t res
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic                          done_valid;
    logic                          done_take;
    sas_pkg::res_t                 done;
    logic                          wr_en;
    logic [ADDR_W-1:0]             wr_addr;
    logic [sas_pkg::VALUE_W-1:0]   wr_data;
    logic                          rd_en;
    logic [ADDR_W-1:0]             rd_addr;
    logic [sas_pkg::VALUE_W-1:0]   rd_data;

    logic                          res_valid_reg, res_valid_next;
    sas_pkg::res_t                 res_reg;

    sas_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W),
        .ADDR_W   (ADDR_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .done_valid (done_valid),
        .done_take  (done_take),
        .done       (done),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    sas_mem #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Take a finished result whenever the output register is free or
    // is being emptied this cycle.
    assign done_take = !res_valid_reg || !res_stall;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (done_valid && done_take)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    // Hold the payload unless a new result is loaded.
    always_ff @(posedge clk)
    begin
        if (done_valid && done_take)
        begin
            res_reg <= done;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

@@ sv/sas_mem.sv @@
// Element store of the sorted set: one write port, one registered read port.
// Depends on sas_pkg for the element width.
module sas_mem #(
    parameter int DEPTH  = sas_pkg::CAPACITY_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [sas_pkg::VALUE_W-1:0]   wr_data,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic [sas_pkg::VALUE_W-1:0]   rd_data
);

    logic [sas_pkg::VALUE_W-1:0] mem_reg [DEPTH];
    logic [sas_pkg::VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/sas_ctrl.sv @@
// Sequencer of the sorted set: linear search through one comparator, then
// shift entries one per cycle. Depends on sas_pkg; drives the sas_mem ports.
module sas_ctrl #(
    parameter int CAPACITY = sas_pkg::CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1),
    parameter int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  sas_pkg::cmd_t                 cmd,
    output logic                          done_valid,
    input  logic                          done_take,
    output sas_pkg::res_t                 done,
    output logic                          wr_en,
    output logic [ADDR_W-1:0]             wr_addr,
    output logic [sas_pkg::VALUE_W-1:0]   wr_data,
    output logic                          rd_en,
    output logic [ADDR_W-1:0]             rd_addr,
    input  logic [sas_pkg::VALUE_W-1:0]   rd_data
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SRCH = 7'b0000010,
        ST_ACT  = 7'b0000100,
        ST_SHUP = 7'b0001000,
        ST_PUT  = 7'b0010000,
        ST_SHDN = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    localparam logic [CNT_W-1:0] ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

    state_t                            state_reg, state_next;
    sas_pkg::kind_t                    kind_reg, kind_next;
    logic signed [sas_pkg::VALUE_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0]                  idx_reg, idx_next;
    logic [CNT_W-1:0]                  pos_reg, pos_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic                              present_reg, present_next;
    logic                              was_reg, was_next;
    logic                              chg_reg, chg_next;

    logic [CNT_W-1:0]                  rd_idx, wr_idx;
    logic                              lt;
    logic [CNT_W+sas_pkg::OUT_CNT_W-1:0] count_wide;

    // The one shared comparator: stored entry against the operand.
    assign lt = $signed(rd_data) < value_reg;

    assign rd_addr = rd_idx[ADDR_W-1:0];
    assign wr_addr = wr_idx[ADDR_W-1:0];

    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        value_next   = value_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        present_next = present_reg;
        was_next     = was_reg;
        chg_next     = chg_reg;
        rd_en        = 1'b0;
        rd_idx       = idx_reg;
        wr_en        = 1'b0;
        wr_idx       = idx_reg;
        wr_data      = rd_data;
        cmd_stall    = 1'b1;
        done_valid   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                cmd_stall = 1'b0;
                if (cmd_valid)
                begin
                    kind_next  = cmd.kind;
                    value_next = cmd.value;
                    was_next   = 1'b0;
                    chg_next   = 1'b0;
                    if (cmd.kind == sas_pkg::OP_CLEAR)
                    begin
                        chg_next   = (count_reg != '0);
                        count_next = '0;
                        state_next = ST_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        pos_next     = '0;
                        present_next = 1'b0;
                        state_next   = ST_ACT;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_idx     = '0;
                        idx_next   = '0;
                        state_next = ST_SRCH;
                    end
                end
            end
            ST_SRCH:
            begin
                // rd_data holds entry idx_reg
                if (lt)
                begin
                    if (idx_reg + ONE == count_reg)
                    begin
                        pos_next     = count_reg;
                        present_next = 1'b0;
                        state_next   = ST_ACT;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_idx   = idx_reg + ONE;
                        idx_next = idx_reg + ONE;
                    end
                end
                else
                begin
                    pos_next     = idx_reg;
                    present_next = (rd_data == value_reg);
                    state_next   = ST_ACT;
                end
            end
            ST_ACT:
            begin
                was_next   = present_reg;
                state_next = ST_DONE;
                case (kind_reg)
                    sas_pkg::OP_INSERT:
                    begin
                        if (!present_reg && count_reg != CAP)
                        begin
                            chg_next = 1'b1;
                            if (pos_reg == count_reg)
                            begin
                                state_next = ST_PUT;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_idx     = count_reg - ONE;
                                idx_next   = count_reg - ONE;
                                state_next = ST_SHUP;
                            end
                        end
                    end
                    sas_pkg::OP_DELETE:
                    begin
                        if (present_reg)
                        begin
                            chg_next = 1'b1;
                            if (pos_reg + ONE == count_reg)
                            begin
                                count_next = count_reg - ONE;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_idx     = pos_reg + ONE;
                                idx_next   = pos_reg + ONE;
                                state_next = ST_SHDN;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SHUP:
            begin
                // move entry idx up one slot, fetch the one below
                wr_en  = 1'b1;
                wr_idx = idx_reg + ONE;
                if (idx_reg == pos_reg)
                begin
                    state_next = ST_PUT;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_idx   = idx_reg - ONE;
                    idx_next = idx_reg - ONE;
                end
            end
            ST_PUT:
            begin
                wr_en      = 1'b1;
                wr_idx     = pos_reg;
                wr_data    = value_reg;
                count_next = count_reg + ONE;
                state_next = ST_DONE;
            end
            ST_SHDN:
            begin
                // move entry idx down one slot, fetch the one above
                wr_en  = 1'b1;
                wr_idx = idx_reg - ONE;
                if (idx_reg + ONE == count_reg)
                begin
                    count_next = count_reg - ONE;
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_idx   = idx_reg + ONE;
                    idx_next = idx_reg + ONE;
                end
            end
            ST_DONE:
            begin
                done_valid = 1'b1;
                if (done_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign count_wide       = (CNT_W + sas_pkg::OUT_CNT_W)'(count_reg);
    assign done.was_present = was_reg;
    assign done.changed     = chg_reg;
    assign done.entry_count = count_wide[sas_pkg::OUT_CNT_W-1:0];
    assign done.is_empty    = (count_reg == '0);
    assign done.is_full     = (count_reg == CAP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        value_reg   <= value_next;
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        present_reg <= present_next;
        was_reg     <= was_next;
        chg_reg     <= chg_next;
    end

endmodule

@@ sv/sas_chk.sv @@
// Port-level checker of the sorted set block, bound to the top level.
// Depends on sas_pkg and the macros in sorted_array_set_assert.svh.
`include "sorted_array_set_assert.svh"

module sas_chk (
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_stall,
    input logic          res_valid,
    input logic          res_stall,
    input sas_pkg::res_t res
);

    // A stalled result holds.
    `SAS_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))

    // A command transfer leaves the block busy in the next cycle.
    `SAS_ASSERT_NEXT(a_busy_after_cmd, cmd_valid && !cmd_stall, cmd_stall)

    // Empty means a zero count and never full.
    `SAS_ASSERT_NOW(a_empty_cnt, res_valid && res.is_empty, res.entry_count == '0 && !res.is_full)

    // A nonzero count is never reported empty.
    `SAS_ASSERT_NOW(a_cnt_empty, res_valid && res.entry_count != '0, !res.is_empty)

endmodule

bind sorted_array_set sas_chk u_sas_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

@@ sim/tb.sv @@
// Self-checking testbench for the sorted_array_set block: directed and random
// set operations. Needs sas_pkg and the sorted_array_set RTL.
// An in-bench model of the sorted set predicts each result.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP        = sas_pkg::CAPACITY_DEF;
    localparam int RANDOM_OPS = 1600;
    // The slowest legal transfer is a full search and shift, plus a
    // long sender gap and a long receiver stall. Allow several times that
    // for every item.
    localparam int MAX_CYCLES = 2_000_000;
    // Quiet period after the last result: long enough for one full search
    // and shift, so a stray extra result would still be seen.
    localparam int TAIL       = 2 * CAP + 16;

    localparam logic [sas_pkg::VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [sas_pkg::VALUE_W-1:0] VAL_MAX = 32'h7fff_ffff;

    // One planned command. settle holds the command back until every
    // result already due has come out of the block.
    typedef struct packed {
        logic          settle;
        sas_pkg::cmd_t op;
    } planned_cmd_t;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           cmd_valid = 1'b0;
    logic           res_stall = 1'b0;
    sas_pkg::cmd_t  cmd       = '0;
    logic           cmd_stall;
    logic           res_valid;
    sas_pkg::res_t  res;

    planned_cmd_t   cmd_backlog[$];
    sas_pkg::res_t  due_results[$];

    // In-bench copy of the set: ascending signed values and their count.
    logic signed [sas_pkg::VALUE_W-1:0] shadow_items [CAP];
    int                                 shadow_count = 0;

    int  mismatches   = 0;
    int  results_seen = 0;
    int  cycle_count  = 0;
    bit  cmd_taken    = 1'b0;
    int  send_gap     = 0;
    int  send_quiet   = 0;
    int  stall_left   = 0;
    int  recv_quiet   = 0;

    sorted_array_set #(
        .CAPACITY (CAP)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        forever #6 clk = ~clk;
    end

    // Hold reset low from the start, then release it away from the rising edge.
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
    end

    // Watchdog: a hung handshake or a missing result ends up here.
    initial
    begin
        while (cycle_count < MAX_CYCLES)
            @(posedge clk);
        $display("[sorted_array_set] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Set model: apply one command and return the result it should give
    // ------------------------------------------------------------------
    function automatic sas_pkg::res_t step_shadow(sas_pkg::cmd_t c);
        sas_pkg::res_t                      r;
        logic signed [sas_pkg::VALUE_W-1:0] v;
        int                                 pos;
        bit                                 hit;
        v   = c.value;
        pos = 0;
        // The first slot not below v. Search linearly, as the block does.
        while (pos < shadow_count && shadow_items[pos] < v)
            pos++;
        hit = (pos < shadow_count) && (shadow_items[pos] == v);
        r   = '0;
        case (c.kind)
            sas_pkg::OP_INSERT:
            begin
                r.was_present = hit;
                // A full set refuses new values. A value already present is left alone.
                if (!hit && shadow_count < CAP)
                begin
                    for (int j = shadow_count; j > pos; j--)
                        shadow_items[j] = shadow_items[j-1];
                    shadow_items[pos] = v;
                    shadow_count++;
                    r.changed = 1'b1;
                end
            end
            sas_pkg::OP_DELETE:
            begin
                r.was_present = hit;
                if (hit)
                begin
                    for (int j = pos; j + 1 < shadow_count; j++)
                        shadow_items[j] = shadow_items[j+1];
                    shadow_count--;
                    r.changed = 1'b1;
                end
            end
            sas_pkg::OP_QUERY:
                r.was_present = hit;
            default:
            begin
                // Clear ignores the value. It counts as a change only if something was held.
                r.changed    = (shadow_count != 0);
                shadow_count = 0;
            end
        endcase
        r.entry_count = shadow_count[sas_pkg::OUT_CNT_W-1:0];
        r.is_empty    = (shadow_count == 0);
        r.is_full     = (shadow_count == CAP);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic void queue_op(sas_pkg::kind_t k, logic [sas_pkg::VALUE_W-1:0] v,
                                     bit settle = 1'b0);
        planned_cmd_t p;
        p.settle   = settle;
        p.op.kind  = k;
        p.op.value = v;
        cmd_backlog.push_back(p);
    endfunction

    // Idle length: mostly short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 93)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < 100)
            $display("%0t mismatch: %s", $time, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Command driver
    // ------------------------------------------------------------------
    // Record each command transfer at the rising edge and predict its result
    // on the spot, so the model follows the block's own order.
    always @(posedge clk)
    begin
        if (rst_n && cmd_valid && !cmd_stall)
        begin
            due_results.push_back(step_shadow(cmd));
            cmd_taken = 1'b1;
        end
    end

    // Drive at the falling edge. Hold a stalled command unchanged. After a
    // transfer, either go straight on to the next command or idle for a
    // random gap first. A settling command waits until nothing is due.
    always @(negedge clk)
    begin
        planned_cmd_t nxt;
        if (rst_n && !(cmd_valid && !cmd_taken))
        begin
            if (cmd_taken)
            begin
                cmd_taken = 1'b0;
                if (send_quiet > 0)
                    send_quiet--;
                else if ($urandom_range(0, 99) < 2)
                    send_quiet = $urandom_range(30, 120);
                else if ($urandom_range(0, 1) == 1)
                    send_gap = pick_gap();
            end
            if (send_gap > 0)
            begin
                cmd_valid <= 1'b0;
                send_gap--;
            end
            else if (cmd_backlog.size() != 0
                     && (!cmd_backlog[0].settle || due_results.size() == 0))
            begin
                nxt = cmd_backlog.pop_front();
                cmd       <= nxt.op;
                cmd_valid <= 1'b1;
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result side: random back-pressure and checking
    // ------------------------------------------------------------------
    // Stall at random, in bursts that are mostly short. Now and then leave
    // a quiet stretch with no stall at all.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            res_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            res_stall <= 1'b0;
            if (recv_quiet > 0)
                recv_quiet--;
            else if ($urandom_range(0, 199) == 0)
                recv_quiet = $urandom_range(40, 200);
            else if ($urandom_range(0, 99) < 20)
                stall_left = pick_gap();
        end
    end

    // Compare each result transfer, field by field, with the oldest result due.
    always @(posedge clk)
    begin
        sas_pkg::res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            results_seen++;
            if (due_results.size() == 0)
                report_mismatch($sformatf("result %0d arrived with none due", results_seen));
            else
            begin
                want = due_results.pop_front();
                if (res.was_present !== want.was_present)
                    report_mismatch($sformatf("result %0d was_present %b, want %b",
                                              results_seen, res.was_present, want.was_present));
                if (res.changed !== want.changed)
                    report_mismatch($sformatf("result %0d changed %b, want %b",
                                              results_seen, res.changed, want.changed));
                if (res.entry_count !== want.entry_count)
                    report_mismatch($sformatf("result %0d entry_count %0d, want %0d",
                                              results_seen, res.entry_count, want.entry_count));
                if (res.is_empty !== want.is_empty)
                    report_mismatch($sformatf("result %0d is_empty %b, want %b",
                                              results_seen, res.is_empty, want.is_empty));
                if (res.is_full !== want.is_full)
                    report_mismatch($sformatf("result %0d is_full %b, want %b",
                                              results_seen, res.is_full, want.is_full));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus plan and end of run
    // ------------------------------------------------------------------
    initial
    begin
        logic [sas_pkg::VALUE_W-1:0] held[$];
        logic [sas_pkg::VALUE_W-1:0] pool[$];
        logic [sas_pkg::VALUE_W-1:0] v;
        logic [sas_pkg::VALUE_W-1:0] base;
        sas_pkg::kind_t              k_op;
        bit                          settle;
        int                          phase_no;
        int                          n_directed;
        int                          order;
        int                          step;
        int                          k;
        int                          n;
        int                          r;
        int                          w_ins;
        int                          w_del;
        int                          w_qry;

        // Directed cases. First the empty set: a query, a delete of an absent
        // value, and a clear that changes nothing.
        queue_op(sas_pkg::OP_QUERY,  32'd0);
        queue_op(sas_pkg::OP_DELETE, 32'd5);
        queue_op(sas_pkg::OP_CLEAR,  32'hdead_beef);
        // Insert the signed extremes and values around zero, out of order.
        queue_op(sas_pkg::OP_INSERT, VAL_MIN);
        queue_op(sas_pkg::OP_INSERT, VAL_MAX);
        queue_op(sas_pkg::OP_INSERT, 32'd0);
        queue_op(sas_pkg::OP_INSERT, 32'hffff_ffff);
        queue_op(sas_pkg::OP_INSERT, 32'd1);
        queue_op(sas_pkg::OP_INSERT, 32'h5555_5555);
        queue_op(sas_pkg::OP_INSERT, 32'haaaa_aaaa);
        // Insert a value already present: the set is left alone.
        queue_op(sas_pkg::OP_INSERT, VAL_MIN);
        queue_op(sas_pkg::OP_QUERY,  VAL_MAX);
        queue_op(sas_pkg::OP_QUERY,  32'd2);
        // Delete from the middle, the first slot and the last slot, then
        // delete one value again, now absent.
        queue_op(sas_pkg::OP_DELETE, 32'd0);
        queue_op(sas_pkg::OP_DELETE, VAL_MIN);
        queue_op(sas_pkg::OP_DELETE, VAL_MAX);
        queue_op(sas_pkg::OP_DELETE, 32'd0);
        queue_op(sas_pkg::OP_QUERY,  32'hffff_ffff);
        // Clear a set that holds values, then query after the clear.
        queue_op(sas_pkg::OP_CLEAR,  32'h0000_0000);
        queue_op(sas_pkg::OP_QUERY,  32'hffff_ffff);
        queue_op(sas_pkg::OP_INSERT, 32'h8000_0001);
        n_directed = cmd_backlog.size();

        // Random phases. Some fill the set to capacity and push on it, and the
        // rest mix operations over a value pool, weighted towards growing or
        // shrinking. The first phase always waits for the block to drain.
        phase_no = 0;
        while (cmd_backlog.size() < n_directed + RANDOM_OPS)
        begin
            settle = (phase_no == 0) || ($urandom_range(0, 9) == 0);
            phase_no++;
            if ($urandom_range(0, 3) == 0)
            begin
                held.delete();
                queue_op(sas_pkg::OP_CLEAR, $urandom, settle);
                // Ascending, descending or scattered order. Descending order
                // makes every insert shift the whole store.
                order = $urandom_range(0, 2);
                base  = $urandom;
                step  = $urandom_range(1, 5000);
                for (int i = 0; i < CAP; i++)
                begin
                    if (order == 0)
                        v = base + i * step;
                    else if (order == 1)
                        v = base - i * step;
                    else
                        v = $urandom;
                    held.push_back(v);
                    queue_op(sas_pkg::OP_INSERT, v);
                end
                // Full set: refuse a value already present and a new one.
                queue_op(sas_pkg::OP_INSERT, held[$urandom_range(0, CAP - 1)]);
                queue_op(sas_pkg::OP_INSERT, $urandom);
                queue_op(sas_pkg::OP_QUERY,  held[$urandom_range(0, CAP - 1)]);
                // Free one slot, refill it, then fail to put the old value back.
                k = $urandom_range(0, CAP - 1);
                queue_op(sas_pkg::OP_DELETE, held[k]);
                queue_op(sas_pkg::OP_INSERT, $urandom);
                queue_op(sas_pkg::OP_INSERT, held[k]);
                // Drain it back down, with repeats that miss.
                n = $urandom_range(4, 80);
                repeat (n)
                begin
                    if ($urandom_range(0, 9) < 7)
                        queue_op(sas_pkg::OP_DELETE, held[$urandom_range(0, CAP - 1)]);
                    else
                        queue_op(sas_pkg::OP_QUERY, held[$urandom_range(0, CAP - 1)]);
                end
            end
            else
            begin
                pool.delete();
                n = $urandom_range(4, 100);
                repeat (n)
                begin
                    r = $urandom_range(0, 9);
                    if (r < 2)
                    begin
                        case ($urandom_range(0, 5))
                            0:       pool.push_back(VAL_MIN);
                            1:       pool.push_back(VAL_MAX);
                            2:       pool.push_back(32'd0);
                            3:       pool.push_back(32'hffff_ffff);
                            4:       pool.push_back(VAL_MIN + 1);
                            default: pool.push_back(VAL_MAX - 1);
                        endcase
                    end
                    else if (r < 5)
                        pool.push_back($urandom_range(0, 64) - 32);
                    else
                        pool.push_back($urandom);
                end
                w_ins = $urandom_range(20, 70);
                w_del = $urandom_range(10, 50);
                w_qry = 25;
                queue_op(sas_pkg::OP_QUERY, pool[0], settle);
                n = $urandom_range(20, 120);
                repeat (n)
                begin
                    r = $urandom_range(0, w_ins + w_del + w_qry + 2);
                    if ($urandom_range(0, 11) == 0)
                        v = $urandom;
                    else
                        v = pool[$urandom_range(0, pool.size() - 1)];
                    if (r < w_ins)
                        k_op = sas_pkg::OP_INSERT;
                    else if (r < w_ins + w_del)
                        k_op = sas_pkg::OP_DELETE;
                    else if (r < w_ins + w_del + w_qry)
                        k_op = sas_pkg::OP_QUERY;
                    else
                        k_op = sas_pkg::OP_CLEAR;
                    queue_op(k_op, v);
                end
            end
        end

        // Wait for every command to be taken, then for every result, then
        // stay on a while to catch any stray extra result.
        while (cmd_backlog.size() != 0 || cmd_valid)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);

        if (mismatches == 0)
            $display("[sorted_array_set] OK");
        else
            $display("[sorted_array_set] ERROR");
        $finish;
    end

endmodule
